// ===== design/sdac_pkg.sv =====
// ----------------------------------------------------------------------------
// sdac_pkg: shared types and constants for the decimal text converter
// Holds the double-dabble stage word, the ASCII codes and the step function
// that every pipeline stage after the input register applies.
// ----------------------------------------------------------------------------
package sdac_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned DIGIT_W      = 4;
  localparam int unsigned NUM_DIGITS   = 10;
  localparam int unsigned BCD_W        = NUM_DIGITS * DIGIT_W;
  localparam int unsigned STEPS_PER_STG = 8;
  localparam int unsigned NUM_STAGES   = DATA_W / STEPS_PER_STG + 1;
  localparam int unsigned IDX_W        = 4;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

  // One word in flight through the converter.
  typedef struct packed {
    logic              neg;
    logic [DATA_W-1:0] bin;
    logic [BCD_W-1:0]  bcd;
  } dd_stage_t;

  // Eight shift-add-3 steps: digits of five or more get three added, then
  // the whole BCD and binary word shifts left by one.
  function automatic dd_stage_t dd_step8(input dd_stage_t s);
    dd_stage_t r;
    r = s;
    for (int k = 0; k < STEPS_PER_STG; k++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (r.bcd[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
          r.bcd[d*DIGIT_W +: DIGIT_W] = r.bcd[d*DIGIT_W +: DIGIT_W] + 4'd3;
        end
      end
      r.bcd = {r.bcd[BCD_W-2:0], r.bin[DATA_W-1]};
      r.bin = {r.bin[DATA_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ===== design/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: 32-bit signed integer to decimal ASCII text
// A five-stage double-dabble pipeline converts the magnitude to BCD, and a
// serializer sends the sign and digits most significant first.
//
//   Channel   Signals                        Direction  Handshake
//   input     start_i, busy_o, value_i       in         start_i && !busy_o
//   result    valid_o, char_code_o, last_o   out        valid_o strobe
//
// A word that is taken passes through the input register and four stages
// of eight shift-add-3 steps each before it reaches the serializer. The
// serializer then sends one character per cycle, 1 to 11 per word.
// Up to five further words wait in the pipeline; busy_o rises once they
// back up to the input register. Reset clears all valid bits; nothing else
// is needed. The receiver takes every strobed character.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [sdac_pkg::DATA_W-1:0] value_i,
  output logic                          valid_o,
  output logic [sdac_pkg::CHAR_W-1:0]   char_code_o,
  output logic                          last_o
);
  import sdac_pkg::*;

  logic      [NUM_STAGES-1:0] valid_q;
  dd_stage_t                  pipe_q [NUM_STAGES];
  logic      [NUM_STAGES-1:0] adv;
  logic                       accept;
  logic                       emit_ready;
  logic                       emit_ld;
  logic      [DATA_W-1:0]     mag;
  dd_stage_t                  entry;

  // A stage takes new data when it is empty or its word moves on.
  always_comb begin
    adv[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || emit_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      adv[i] = !valid_q[i] || adv[i+1];
    end
  end

  assign busy_o  = valid_q[0] && !adv[0];
  assign accept  = start_i && !busy_o;
  assign emit_ld = valid_q[NUM_STAGES-1] && emit_ready;

  // Magnitude in unsigned arithmetic; the most negative value maps exactly.
  assign mag       = value_i[DATA_W-1] ? (DATA_W'(0) - DATA_W'(value_i)) : DATA_W'(value_i);
  assign entry.neg = value_i[DATA_W-1];
  assign entry.bin = mag;
  assign entry.bcd = '0;

  // Valid bits of the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= accept;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (adv[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  // Data of the pipeline: each stage after the first applies eight conversion steps.
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      pipe_q[0] <= entry;
    end
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (adv[i]) begin
        pipe_q[i] <= dd_step8(pipe_q[i-1]);
      end
    end
  end

  // Character serializer.
  sdac_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ld_i        (emit_ld),
    .ld_data_i   (pipe_q[NUM_STAGES-1]),
    .ready_o     (emit_ready),
    .valid_o     (valid_o),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

endmodule

// ===== design/sdac_emit.sv =====
// ----------------------------------------------------------------------------
// sdac_emit: character serializer
// Takes one converted word, finds its leading digit and sends the optional
// minus sign and then the digits, one character per cycle.
// ----------------------------------------------------------------------------
module sdac_emit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             ld_i,
  input  sdac_pkg::dd_stage_t              ld_data_i,
  output logic                             ready_o,
  output logic                             valid_o,
  output logic [sdac_pkg::CHAR_W-1:0]      char_code_o,
  output logic                             last_o
);
  import sdac_pkg::*;

  logic                 busy_q, busy_d;
  logic                 minus_q, minus_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [BCD_W-1:0]     bcd_q;
  logic [IDX_W-1:0]     top_idx;
  logic [DIGIT_W-1:0]   cur_digit;
  logic                 finishing;

  // Position of the most significant nonzero digit; zero when all are zero.
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (ld_data_i.bcd[d*DIGIT_W +: DIGIT_W] != '0) begin
        top_idx = IDX_W'(d);
      end
    end
  end

  assign cur_digit = bcd_q[{idx_q, 2'b00} +: DIGIT_W];
  assign finishing = busy_q && !minus_q && (idx_q == '0);
  assign ready_o   = !busy_q || finishing;

  // Output character: minus sign first when pending, then the digits.
  assign valid_o     = busy_q;
  assign char_code_o = minus_q ? ASCII_MINUS : (ASCII_ZERO + CHAR_W'(cur_digit));
  assign last_o      = finishing;

  // Next-state logic for the sequencer.
  always_comb begin
    busy_d  = busy_q;
    minus_d = minus_q;
    idx_d   = idx_q;
    if (busy_q) begin
      if (minus_q) begin
        minus_d = 1'b0;
      end else if (idx_q != '0) begin
        idx_d = idx_q - 1'b1;
      end else begin
        busy_d = 1'b0;
      end
    end
    if (ld_i) begin
      busy_d  = 1'b1;
      minus_d = ld_data_i.neg;
      idx_d   = top_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      minus_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      minus_q <= minus_d;
      idx_q   <= idx_d;
    end
  end

  // Digit storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      bcd_q <= ld_data_i.bcd;
    end
  end

`ifndef SYNTH
  a_load_only_when_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_i |-> ready_o)
    else $error("word loaded while serializer still busy");

  a_run_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |=> valid_o)
    else $error("character run broken before its last character");

  a_minus_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && char_code_o == ASCII_MINUS |-> !last_o)
    else $error("minus sign sent as final character");

  a_digit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !minus_q |-> cur_digit <= 4'd9)
    else $error("non-decimal digit sent");
`endif

endmodule
